// File: rtl/core/mpfb_pkg.sv
// Package for the monochrome page framebuffer: panel geometry, action and
// state codes, and the rectangle bundle shared by the top level and mask unit.
// No dependencies.
package mpfb_pkg;

   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int ADDR_W         = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int PAGE_W         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

   typedef enum logic [2:0] {
      ACT_CLEAR   = 3'd0,
      ACT_PIXEL   = 3'd1,
      ACT_FILL    = 3'd2,
      ACT_OUTLINE = 3'd3,
      ACT_READ    = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] w;
      logic [7:0] h;
   } rect_type;

endpackage

// File: rtl/core/mpfb_mask.sv
// Byte mask unit: which of the eight pixels of one page byte a fill, pixel or
// outline action touches. Depends on mpfb_pkg.
module mpfb_mask (
   input  mpfb_pkg::action_type            act,
   input  logic [7:0]                      col,
   input  logic [mpfb_pkg::PAGE_W-1:0]     page,
   input  mpfb_pkg::rect_type              rect,
   output logic [7:0]                      mask
);
   import mpfb_pkg::*;

   logic       col_ok;
   logic       col_span;
   logic       col_edge;

   assign col_ok   = col < 8'(DISPLAY_WIDTH);
   // column lies in x .. x+w-1, wrapping modulo 256
   assign col_span = 8'(col - rect.x) < rect.w;
   assign col_edge = (col == rect.x) || (col == 8'(rect.x + rect.w - 8'd1));

   always_comb begin : mask_calc
      logic [7:0] row;
      logic       row_ok;
      logic       row_span;
      logic       row_edge;
      mask = '0;
      for (int n = 0; n < 8; n++) begin
         row      = 8'({page, 3'(n)});
         row_ok   = row < 8'(DISPLAY_HEIGHT);
         row_span = 8'(row - rect.y) < rect.h;
         row_edge = (row == rect.y) || (row == 8'(rect.y + rect.h - 8'd1));
         case (act)
            ACT_PIXEL, ACT_FILL: begin
               mask[n] = col_ok && row_ok && col_span && row_span;
            end
            ACT_OUTLINE: begin
               mask[n] = col_ok && row_ok &&
                         ((col_span && row_edge) || (col_edge && row_span));
            end
            default: begin
               mask[n] = 1'b0;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/mono_page_framebuffer_draw_top.sv
// Monochrome page framebuffer top level; depends on mpfb_pkg and mpfb_mask.
// Per action after acceptance: pixel and read do one RAM read, then pixel writes the byte back;
// fill and outline read and write every byte of the store; clear writes every byte to zero.
// Off-panel pixels, out-of-range reads and unused action codes skip the store. The next
// transaction is taken only once the result is handed out; a stalled result holds the input.
// Reset: synchronous; a clearing pass over all STORE_BYTES bytes zeroes the store, req_stall high.
module mono_page_framebuffer_draw_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_w,
   input  logic [7:0] req_h,
   input  logic       req_on,
   input  logic [2:0] req_read_page,
   input  logic [6:0] req_read_column,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_byte
);
   import mpfb_pkg::*;

   // Control state
   state_type             state_ff, state_in;
   logic                  from_req_ff, from_req_in;   // clear sweep owes a result
   logic                  single_ff, single_in;       // one byte only (pixel, read)
   logic                  rsp_valid_ff, rsp_valid_in;

   // Transaction payload held for the whole action
   action_type            act_ff, act_in;
   rect_type              rect_ff, rect_in;
   logic                  on_ff, on_in;
   logic [7:0]            res_ff, res_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;

   // Sweep position: column, page and the matching store address
   logic [7:0]            col_ff, col_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;

   // Store
   logic [7:0]            frame_store_mem [STORE_BYTES];
   logic [7:0]            mem_rdata_ff;
   logic                  mem_we;
   logic [7:0]            mem_wdata;

   logic                  accept;
   logic                  rsp_free;
   logic                  sweep_last;
   logic                  clear_last;
   logic [7:0]            byte_mask;
   logic                  set_bits;
   action_type            req_act;
   logic                  pixel_ok;
   logic                  read_ok;

   assign req_act    = action_type'(req_action);
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

   assign sweep_last = (col_ff == 8'(DISPLAY_WIDTH - 1)) &&
                       (page_ff == PAGE_W'(PAGE_COUNT - 1));
   assign clear_last = (addr_ff == ADDR_W'(STORE_BYTES - 1));

   // Off-panel pixels and out-of-range reads never touch the store
   assign pixel_ok = (req_x < 8'(DISPLAY_WIDTH)) && (req_y < 8'(DISPLAY_HEIGHT));
   assign read_ok  = ({5'd0, req_read_page} < 8'(PAGE_COUNT)) &&
                     ({1'b0, req_read_column} < 8'(DISPLAY_WIDTH));

   // Outline always sets; pixel and fill follow the on bit
   assign set_bits = (act_ff == ACT_OUTLINE) || on_ff;

   mpfb_mask u_mask (
      .act  (act_ff),
      .col  (col_ff),
      .page (page_ff),
      .rect (rect_ff),
      .mask (byte_mask)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_act)
                  ACT_CLEAR:             state_in = ST_CLEAR;
                  ACT_PIXEL:             state_in = pixel_ok ? ST_READ : ST_DONE;
                  ACT_FILL, ACT_OUTLINE: state_in = ST_READ;
                  ACT_READ:              state_in = read_ok ? ST_READ : ST_DONE;
                  default:               state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = from_req_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            state_in = (single_ff || sweep_last) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      from_req_in  = from_req_ff;
      single_in    = single_ff;
      act_in       = act_ff;
      rect_in      = rect_ff;
      on_in        = on_ff;
      res_in       = res_ff;
      col_in       = col_ff;
      page_in      = page_ff;
      addr_in      = addr_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_wdata    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Latch the transaction; pixel becomes a 1x1 fill at its own byte
               act_in      = req_act;
               on_in       = req_on;
               res_in      = '0;
               from_req_in = 1'b1;
               rect_in     = '{x: req_x, y: req_y, w: req_w, h: req_h};
               single_in   = 1'b0;
               col_in      = '0;
               page_in     = '0;
               addr_in     = '0;
               case (req_act)
                  ACT_PIXEL: begin
                     single_in = 1'b1;
                     rect_in.w = 8'd1;
                     rect_in.h = 8'd1;
                     col_in    = req_x;
                     page_in   = PAGE_W'(req_y >> 3);
                     addr_in   = ADDR_W'(PAGE_W'(req_y >> 3)) * ADDR_W'(DISPLAY_WIDTH) +
                                 ADDR_W'(req_x);
                  end
                  ACT_READ: begin
                     single_in = 1'b1;
                     page_in   = PAGE_W'(req_read_page);
                     addr_in   = ADDR_W'(PAGE_W'(req_read_page)) * ADDR_W'(DISPLAY_WIDTH) +
                                 ADDR_W'(req_read_column);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            // Zero one byte a cycle; no read needed
            mem_we    = 1'b1;
            mem_wdata = '0;
            addr_in   = addr_ff + ADDR_W'(1);
         end
         ST_READ: begin
            // RAM read of addr_ff is under way; data lands next cycle
         end
         ST_MODIFY: begin
            if (act_ff == ACT_READ) begin
               res_in = mem_rdata_ff;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = set_bits ? (mem_rdata_ff | byte_mask)
                                    : (mem_rdata_ff & ~byte_mask);
            end
            // Advance the sweep column first, then the page
            if (!single_ff && !sweep_last) begin
               addr_in = addr_ff + ADDR_W'(1);
               if (col_ff == 8'(DISPLAY_WIDTH - 1)) begin
                  col_in  = '0;
                  page_in = page_ff + PAGE_W'(1);
               end else begin
                  col_in  = col_ff + 8'd1;
               end
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         from_req_ff  <= 1'b0;
         single_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
         col_ff       <= '0;
         page_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         from_req_ff  <= from_req_in;
         single_ff    <= single_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
         col_ff       <= col_in;
         page_ff      <= page_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      rect_ff     <= rect_in;
      on_ff       <= on_in;
      res_ff      <= res_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   // Single-port store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store_mem[addr_ff] <= mem_wdata;
      end
      mem_rdata_ff <= frame_store_mem[addr_ff];
   end

endmodule

// File: verif/mpfb_draw_checker.sv
// Scoreboard for the page framebuffer: keeps its own copy of the pixel store,
// predicts the byte of every accepted transaction and compares results in order.
// Depends on mpfb_pkg for panel geometry and action codes.
module mpfb_draw_checker
   import mpfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_w,
   input  logic [7:0] req_h,
   input  logic       req_on,
   input  logic [2:0] req_read_page,
   input  logic [6:0] req_read_column,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_read_byte,
   output int         fail_count,
   output int         pending_count
);

   typedef struct {
      logic [7:0] read_byte;
      logic [2:0] action;
      int         serial;
   } byte_expect_type;

   logic [7:0]      pixel_image [STORE_BYTES];
   byte_expect_type owed_bytes [$];
   int              accepted_count;

   function automatic void wipe_image();
      foreach (pixel_image[k]) pixel_image[k] = 8'h00;
   endfunction

   // Coordinates arrive as unbounded sums; wrap to 8 bits, drop anything off the panel.
   function automatic void draw_dot(input int col, input int row, input logic set);
      int c;
      int r;
      int pos;
      c = col & 255;
      r = row & 255;
      if (c >= DISPLAY_WIDTH || r >= DISPLAY_HEIGHT) return;
      pos = c + (r / 8) * DISPLAY_WIDTH;
      pixel_image[pos][r % 8] = set;
   endfunction

   function automatic logic [7:0] run_draw(input logic [2:0] act, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] w,
                                           input logic [7:0] h, input logic on,
                                           input logic [2:0] pg, input logic [6:0] col);
      int i;
      int j;
      logic [7:0] got;
      got = 8'h00;
      case (act)
         ACT_CLEAR: wipe_image();
         ACT_PIXEL: draw_dot(int'(x), int'(y), on);
         ACT_FILL: begin
            for (j = 0; j < int'(h); j++)
               for (i = 0; i < int'(w); i++)
                  draw_dot(int'(x) + i, int'(y) + j, on);
         end
         ACT_OUTLINE: begin
            // outline ignores on; adding 255 is minus one modulo 256
            for (i = 0; i < int'(w); i++) begin
               draw_dot(int'(x) + i, int'(y), 1'b1);
               draw_dot(int'(x) + i, int'(y) + int'(h) + 255, 1'b1);
            end
            for (j = 0; j < int'(h); j++) begin
               draw_dot(int'(x), int'(y) + j, 1'b1);
               draw_dot(int'(x) + int'(w) + 255, int'(y) + j, 1'b1);
            end
         end
         ACT_READ: begin
            if (int'(pg) < PAGE_COUNT && int'(col) < DISPLAY_WIDTH)
               got = pixel_image[int'(col) + int'(pg) * DISPLAY_WIDTH];
         end
         default: ;
      endcase
      return got;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("%0t checker: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      byte_expect_type want;
      if (reset) begin
         wipe_image();
         owed_bytes.delete();
      end else begin
         // retire first: no result can belong to a transaction accepted this edge
         if (rsp_valid && !rsp_stall) begin
            if (owed_bytes.size() == 0) begin
               note_mismatch($sformatf("unexpected result, read_byte %02h", rsp_read_byte));
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_read_byte !== want.read_byte)
                  note_mismatch($sformatf("item %0d action %0d read_byte got %02h want %02h",
                                          want.serial, want.action, rsp_read_byte,
                                          want.read_byte));
            end
         end
         if (req_valid && !req_stall) begin
            want.read_byte = run_draw(req_action, req_x, req_y, req_w, req_h, req_on,
                                      req_read_page, req_read_column);
            want.action = req_action;
            want.serial = accepted_count;
            accepted_count = accepted_count + 1;
            owed_bytes.push_back(want);
         end
      end
      pending_count = owed_bytes.size();
   end

endmodule

// File: verif/tb_mono_page_framebuffer_draw_top.sv
// Testbench top for the page framebuffer: drives directed and random drawing
// transactions with random idling on both channels and gives the verdict.
// Depends on mpfb_pkg, mono_page_framebuffer_draw_top and mpfb_draw_checker.
module tb_mono_page_framebuffer_draw_top;
   import mpfb_pkg::*;

   // action codes the block must ignore
   localparam logic [2:0] ACT_UNUSED_A = 3'd5;
   localparam logic [2:0] ACT_UNUSED_B = 3'd6;
   localparam logic [2:0] ACT_UNUSED_C = 3'd7;

   localparam int RANDOM_ITEMS = 400;
   localparam int IDLE_PERCENT = 7;

   // one request transaction, every field at its port width
   typedef struct packed {
      logic [2:0] action;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] w;
      logic [7:0] h;
      logic       on;
      logic [2:0] read_page;
      logic [6:0] read_column;
   } draw_cmd_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_action;
   logic [7:0] req_x;
   logic [7:0] req_y;
   logic [7:0] req_w;
   logic [7:0] req_h;
   logic       req_on;
   logic [2:0] req_read_page;
   logic [6:0] req_read_column;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_byte;

   // no idling on either side while this is high
   logic       quiet;

   int         fail_count;
   int         pending_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mono_page_framebuffer_draw_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_w           (req_w),
      .req_h           (req_h),
      .req_on          (req_on),
      .req_read_page   (req_read_page),
      .req_read_column (req_read_column),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_byte   (rsp_read_byte)
   );

   mpfb_draw_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_w           (req_w),
      .req_h           (req_h),
      .req_on          (req_on),
      .req_read_page   (req_read_page),
      .req_read_column (req_read_column),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_byte   (rsp_read_byte),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // Stall the result channel now and then; hold it open during the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Every field random over its full width, so bits the action ignores still toggle.
   function automatic draw_cmd_type noise_cmd();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      noise_cmd = r[$bits(draw_cmd_type)-1:0];
   endfunction

   function automatic draw_cmd_type make_cmd(input logic [2:0] act, input logic [7:0] px,
                                             input logic [7:0] py, input logic [7:0] pw,
                                             input logic [7:0] ph, input logic pon,
                                             input logic [2:0] pg, input logic [6:0] pc);
      make_cmd = '{act, px, py, pw, ph, pon, pg, pc};
   endfunction

   // Present one transaction and hold it until the block takes it. Valid stays
   // high from one transaction to the next unless an idle gap is drawn.
   task automatic issue(input draw_cmd_type c);
      if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= c.action;
      req_x           <= c.x;
      req_y           <= c.y;
      req_w           <= c.w;
      req_h           <= c.h;
      req_on          <= c.on;
      req_read_page   <= c.read_page;
      req_read_column <= c.read_column;
      do @(posedge clock); while (req_stall);
   endtask

   // Hard stop. The slowest correct run is every transaction a full-store walk,
   // plus gaps and the reset clearing pass; fifty million time units leaves ample margin.
   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      draw_cmd_type c;
      int           pick;
      int           sel;
      logic [7:0]   last_x;
      logic [7:0]   last_y;

      // drive every input to a known value before the first edge
      reset           <= 1'b1;
      quiet           <= 1'b0;
      req_valid       <= 1'b0;
      req_action      <= ACT_CLEAR;
      req_x           <= 8'h00;
      req_y           <= 8'h00;
      req_w           <= 8'h00;
      req_h           <= 8'h00;
      req_on          <= 1'b0;
      req_read_page   <= 3'd0;
      req_read_column <= 7'd0;
      last_x = 8'h00;
      last_y = 8'h00;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // the block clears its store after reset with req_stall high; issue just waits

      // --- directed part ---
      // store reads zero straight out of reset
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0));
      // corner pixels, then read them back
      issue(make_cmd(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0));
      issue(make_cmd(ACT_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7, 7'd127));
      // pixels off the panel: skip silently
      issue(make_cmd(ACT_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0));
      issue(make_cmd(ACT_PIXEL, 8'd5, 8'd64, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0));
      // clear a single pixel
      issue(make_cmd(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0));
      // empty fills draw nothing
      issue(make_cmd(ACT_FILL, 8'd10, 8'd3, 8'd0, 8'd9, 1'b1, 3'd0, 7'd0));
      issue(make_cmd(ACT_FILL, 8'd10, 8'd3, 8'd9, 8'd0, 1'b1, 3'd0, 7'd0));
      // fill that wraps past 255 back onto the top-left corner
      issue(make_cmd(ACT_FILL, 8'd250, 8'd250, 8'd20, 8'd20, 1'b1, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd5));
      // largest fill, clearing everything
      issue(make_cmd(ACT_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 3'd0, 7'd0));
      // degenerate outline, zero height: rows y and y-1
      issue(make_cmd(ACT_OUTLINE, 8'd20, 8'd8, 8'd6, 8'd0, 1'b0, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd22));
      // degenerate outline, zero width: columns x and x-1; on ignored
      issue(make_cmd(ACT_OUTLINE, 8'd40, 8'd16, 8'd0, 8'd5, 1'b0, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd2, 7'd39));
      // largest outline, wrapping from deep off the panel
      issue(make_cmd(ACT_OUTLINE, 8'd200, 8'd200, 8'd255, 8'd255, 1'b0, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0));
      // unused action codes change nothing
      issue(make_cmd(ACT_UNUSED_A, 8'd1, 8'd1, 8'd255, 8'd255, 1'b1, 3'd0, 7'd0));
      issue(make_cmd(ACT_UNUSED_B, 8'd255, 8'd0, 8'd1, 8'd1, 1'b1, 3'd7, 7'd127));
      issue(make_cmd(ACT_UNUSED_C, 8'd0, 8'd255, 8'd128, 8'd128, 1'b0, 3'd5, 7'd64));
      // clear all, then read the far corner byte
      issue(make_cmd(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0));
      issue(make_cmd(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7, 7'd127));

      // --- random part ---
      // Mostly on-panel drawing with reads aimed at the last drawn spot, so reads
      // see set bits; the rest ranges over every field's full width.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet <= (n >= 150 && n < 250);
         c = noise_cmd();
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            c.action = ACT_CLEAR;
         end else if (pick < 59) begin
            if (pick < 32)
               c.action = ACT_PIXEL;
            else if (pick < 47)
               c.action = ACT_FILL;
            else
               c.action = ACT_OUTLINE;
            // narrow onto the 128 x 64 panel most of the time
            if ($urandom_range(0, 99) < 85) begin
               c.x[7]   = 1'b0;
               c.y[7:6] = 2'b00;
            end
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
               c.w[7:4] = 4'h0;
               c.h[7:4] = 4'h0;
            end
            last_x = c.x;
            last_y = c.y;
         end else if (pick < 96) begin
            c.action = ACT_READ;
            if ($urandom_range(0, 99) < 60) begin
               c.read_page   = last_y[5:3];
               c.read_column = last_x[6:0];
            end
         end else begin
            sel = $urandom_range(0, 2);
            if (sel == 0)
               c.action = ACT_UNUSED_A;
            else if (sel == 1)
               c.action = ACT_UNUSED_B;
            else
               c.action = ACT_UNUSED_C;
         end
         issue(c);
      end

      // --- drain ---
      req_valid <= 1'b0;
      quiet     <= 1'b0;
      // sample the scoreboard away from the rising edge
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      // allow for a stray late result: one full-store walk and a margin
      repeat (2 * STORE_BYTES + 16) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/mpfb_pkg.sv
rtl/core/mpfb_mask.sv
rtl/core/mono_page_framebuffer_draw_top.sv
verif/mpfb_draw_checker.sv
verif/tb_mono_page_framebuffer_draw_top.sv
